// ===== design/ohs_pkg.sv =====
// Shared types and constants of the open-addressing hash set.
package ohs_pkg;
  localparam int unsigned SLOT_BITS = 8;
  localparam int unsigned NSLOTS    = 1 << SLOT_BITS;
  localparam int unsigned KEY_BITS  = 32;
  localparam int unsigned CNT_BITS  = SLOT_BITS + 1;
  localparam int unsigned HASH_BITS = 32;
  localparam int unsigned DIV_CNT_BITS = $clog2(HASH_BITS + 1);
  localparam logic [KEY_BITS-1:0] TOMB_KEY = '1;
  localparam logic [HASH_BITS-1:0] MOD_RESET = HASH_BITS'(251);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_INVALID = 2'd1,
    STS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]           req;
    logic                 bad_key;
    logic [KEY_BITS-1:0]  key;
    logic [HASH_BITS-1:0] hash;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MOD, BK_RD, BK_CMP, BK_RESP
  } bk_state_e;
endpackage

// ===== design/open_addressing_hash_set_top.sv =====
// Top level of the open-addressing hash set.
// A set of up to 256 nonzero 32-bit keys in a table with triangular probing.
// Input channel: in_valid_i / in_stall_o carry one item (req_type_i, key_i,
// key_hash_i); an item is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry one result per item
// (status_o, present_o, slot_o, entry_count_o), held steady while stalled.
// Configuration: cfg_we_i writes cfg_wdata_i into the hash modulus.
// Flow: items run one at a time in the back end. An accepted item passes
// through the queue, the bit-serial modulus unit (skipped for modulus zero),
// a registered store read and a compare for each slot probed, and the result
// register. Reserved keys and clear skip the modulus unit and the probe.
// A two-entry queue between front and back keeps accepting items while the
// back end works or the result waits.
// Reset empties the table at once through per-slot valid bits, zeroes the
// key count, loads modulus 251 and flushes the queue; clear does the same
// to the table.
// A stalled receiver holds the result; the back end waits and the queue
// fills, then in_stall_o rises.
module open_addressing_hash_set_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic [31:0] key_hash_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        present_o,
  output logic [7:0]  slot_o,
  output logic [8:0]  entry_count_o
);
  logic          cmd_valid, cmd_pop;
  ohs_pkg::cmd_t cmd;

  // Accept and classify.
  ohs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .key_i,
    .key_hash_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // Reduce, probe, update, answer.
  ohs_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .cmd_valid_i(cmd_valid),
    .cmd_i(cmd), .cmd_pop_o(cmd_pop), .out_valid_o, .out_stall_i,
    .status_o, .present_o, .slot_o, .entry_count_o
  );
endmodule

// ===== design/ohs_front.sv =====
// Front end: accept and classify items, hold them in a two-entry queue.
module ohs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [31:0]                key_i,
  input  logic [31:0]                key_hash_i,
  output logic                       cmd_valid_o,
  output ohs_pkg::cmd_t              cmd_o,
  input  logic                       cmd_pop_i
);
  ohs_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  ohs_pkg::cmd_t cmd_in;
  logic [ohs_pkg::KEY_BITS-1:0] key_m;

  always_comb begin
    key_m          = key_i[ohs_pkg::KEY_BITS-1:0];
    cmd_in.req     = req_type_i;
    cmd_in.key     = key_m;
    cmd_in.hash    = key_hash_i;
    // Flag reserved keys now so the back end can skip the probe.
    cmd_in.bad_key = (req_type_i != ohs_pkg::REQ_CLEAR) &&
                     ((key_m == '0) || (key_m == ohs_pkg::TOMB_KEY));
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_in;
  end
endmodule

// ===== design/ohs_back.sv =====
// Back end: modulus unit, probe sequencer, slot store and result register.
module ohs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                cmd_valid_i,
  input  ohs_pkg::cmd_t       cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic                present_o,
  output logic [7:0]          slot_o,
  output logic [8:0]          entry_count_o
);
  localparam int unsigned SB = ohs_pkg::SLOT_BITS;
  localparam int unsigned KB = ohs_pkg::KEY_BITS;
  localparam int unsigned HB = ohs_pkg::HASH_BITS;
  localparam int unsigned CB = ohs_pkg::CNT_BITS;

  logic [KB-1:0] mem [ohs_pkg::NSLOTS];
  logic [ohs_pkg::NSLOTS-1:0] vld_q;
  logic [KB-1:0] rdata_q;
  logic          rvld_q;

  ohs_pkg::bk_state_e state_q, state_d;
  logic [HB-1:0] mod_q;
  ohs_pkg::cmd_t cur_q;
  logic [HB:0]   rem_q, rem_d;
  logic [HB-1:0] quo_q, quo_d;
  logic [ohs_pkg::DIV_CNT_BITS-1:0] dcnt_q, dcnt_d;
  logic [SB-1:0] idx_q, idx_d, tomb_q, tomb_d;
  logic          have_tomb_q, have_tomb_d;
  logic [SB:0]   step_q, step_d;
  logic [CB-1:0] live_q, live_d;
  logic [1:0]    rsts_q, rsts_d;
  logic          rpres_q, rpres_d;
  logic [SB-1:0] rslot_q, rslot_d;
  logic          ovld_q;
  logic [1:0]    osts_q;
  logic          opres_q;
  logic [SB-1:0] oslot_q;
  logic [CB-1:0] ocnt_q;

  logic          we, clr_all, out_load;
  logic [SB-1:0] waddr;
  logic [KB-1:0] wdata;
  logic [KB-1:0] v;
  logic [HB:0]   rem_sh;
  logic [SB-1:0] pos;
  logic [KB-1:0] vpos;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    idx_d       = idx_q;
    tomb_d      = tomb_q;
    have_tomb_d = have_tomb_q;
    step_d      = step_q;
    live_d      = live_q;
    rsts_d      = rsts_q;
    rpres_d     = rpres_q;
    rslot_d     = rslot_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    clr_all     = 1'b0;
    waddr       = idx_q;
    wdata       = cur_q.key;
    out_load    = 1'b0;
    v           = rvld_q ? rdata_q : '0;
    rem_sh      = {rem_q[HB-1:0], quo_q[HB-1]};
    pos         = have_tomb_q ? tomb_q : idx_q;
    vpos        = have_tomb_q ? ohs_pkg::TOMB_KEY : v;

    case (state_q)
      ohs_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          rsts_d      = ohs_pkg::STS_DONE;
          rpres_d     = 1'b0;
          rslot_d     = '0;
          have_tomb_d = 1'b0;
          tomb_d      = '0;
          step_d      = '0;
          rem_d       = '0;
          quo_d       = cmd_i.hash;
          dcnt_d      = '0;
          idx_d       = cmd_i.hash[SB-1:0];
          if (cmd_i.req == ohs_pkg::REQ_CLEAR) begin
            clr_all = 1'b1;
            live_d  = '0;
            state_d = ohs_pkg::BK_RESP;
          end else if (cmd_i.bad_key) begin
            rsts_d  = ohs_pkg::STS_INVALID;
            state_d = ohs_pkg::BK_RESP;
          end else if (mod_q == '0) begin
            state_d = ohs_pkg::BK_RD;
          end else begin
            state_d = ohs_pkg::BK_MOD;
          end
        end
      end
      ohs_pkg::BK_MOD: begin
        // One quotient bit a cycle; keep the remainder.
        quo_d = {quo_q[HB-2:0], 1'b0};
        if (rem_sh >= {1'b0, mod_q}) rem_d = rem_sh - {1'b0, mod_q};
        else rem_d = rem_sh;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == ohs_pkg::DIV_CNT_BITS'(HB - 1)) begin
          idx_d   = rem_d[SB-1:0];
          state_d = ohs_pkg::BK_RD;
        end
      end
      ohs_pkg::BK_RD: begin
        state_d = ohs_pkg::BK_CMP;
      end
      ohs_pkg::BK_CMP: begin
        if (v == cur_q.key) begin
          rpres_d = 1'b1;
          rslot_d = idx_q;
          if (cur_q.req == ohs_pkg::REQ_REMOVE) begin
            we     = 1'b1;
            wdata  = ohs_pkg::TOMB_KEY;
            live_d = live_q - 1'b1;
          end
          state_d = ohs_pkg::BK_RESP;
        end else if ((v == '0) || (step_q == (SB+1)'(ohs_pkg::NSLOTS - 1))) begin
          if (cur_q.req == ohs_pkg::REQ_INSERT) begin
            if ((vpos == '0) || (vpos == ohs_pkg::TOMB_KEY)) begin
              we      = 1'b1;
              waddr   = pos;
              live_d  = live_q + 1'b1;
              rslot_d = pos;
            end else begin
              rsts_d = ohs_pkg::STS_FULL;
            end
          end
          state_d = ohs_pkg::BK_RESP;
        end else begin
          if ((v == ohs_pkg::TOMB_KEY) && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_d      = idx_q;
          end
          step_d  = step_q + 1'b1;
          idx_d   = idx_q + step_d[SB-1:0];
          state_d = ohs_pkg::BK_RD;
        end
      end
      ohs_pkg::BK_RESP: begin
        if (!ovld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ohs_pkg::BK_IDLE;
        end
      end
      default: state_d = ohs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ohs_pkg::BK_IDLE;
      mod_q   <= ohs_pkg::MOD_RESET;
      live_q  <= '0;
      vld_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
      if (clr_all) vld_q <= '0;
      else if (we) vld_q[waddr] <= 1'b1;
      if (out_load) ovld_q <= 1'b1;
      else if (!out_stall_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dcnt_q      <= dcnt_d;
    idx_q       <= idx_d;
    tomb_q      <= tomb_d;
    have_tomb_q <= have_tomb_d;
    step_q      <= step_d;
    rsts_q      <= rsts_d;
    rpres_q     <= rpres_d;
    rslot_q     <= rslot_d;
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[idx_q];
    rvld_q  <= vld_q[idx_q];
    if (out_load) begin
      osts_q  <= rsts_q;
      opres_q <= rpres_q;
      oslot_q <= rslot_q;
      ocnt_q  <= live_q;
    end
  end

  assign out_valid_o   = ovld_q;
  assign status_o      = osts_q;
  assign present_o     = opres_q;
  assign slot_o        = oslot_q;
  assign entry_count_o = ocnt_q;
endmodule

// ===== design/ohs_checker.sv =====
// Port-level checks of the hash set, bound to the top level.
module ohs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic       present_o,
  input logic [7:0] slot_o,
  input logic [8:0] entry_count_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o))
    else $error("result changed under stall");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= 9'd256)
    else $error("entry count too large");
  a_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ohs_pkg::STS_INVALID |-> !present_o && slot_o == 8'd0)
    else $error("invalid key with slot or present");
  a_pres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && present_o |-> status_o == ohs_pkg::STS_DONE)
    else $error("present with bad status");
endmodule

bind open_addressing_hash_set_top ohs_checker u_ohs_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .status_o, .present_o,
  .slot_o, .entry_count_o
);

// ===== verif/open_addressing_hash_set_checker.sv =====
// Checker of the hash set: predicts each result and compares it with the block.
module open_addressing_hash_set_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic [31:0] key_hash_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  status_o,
  input  logic        present_o,
  input  logic [7:0]  slot_o,
  input  logic [8:0]  entry_count_o,
  output int          fail_count,
  output int          pending_count
);
  typedef struct packed {
    ohs_pkg::status_e status;
    logic             present;
    logic [7:0]       slot;
    logic [8:0]       count;
  } answer_t;

  logic [ohs_pkg::KEY_BITS-1:0] table_q [ohs_pkg::NSLOTS];
  logic [8:0]  live_q;
  logic [31:0] modulus_q;
  answer_t     answers_q [$];

  function automatic logic [7:0] probe(logic [31:0] k, logic [31:0] h);
    logic [31:0] home;
    logic [7:0]  idx;
    logic [7:0]  tomb_idx;
    logic        have_tomb;
    int          step;
    home = (modulus_q != 0) ? h % modulus_q : h;
    idx = home[7:0];
    have_tomb = 1'b0;
    tomb_idx = '0;
    for (step = 1; step <= ohs_pkg::NSLOTS; step++) begin
      if (table_q[idx] == k) return idx;
      if (table_q[idx] == '0) break;
      if (table_q[idx] == ohs_pkg::TOMB_KEY && !have_tomb) begin
        have_tomb = 1'b1;
        tomb_idx = idx;
      end
      if (step == ohs_pkg::NSLOTS) break;
      idx = idx + 8'(step);
    end
    return have_tomb ? tomb_idx : idx;
  endfunction

  task automatic apply_request(ohs_pkg::req_e req, logic [31:0] k, logic [31:0] h);
    answer_t a;
    logic [7:0] pos;
    logic hit;
    a = '{ohs_pkg::STS_DONE, 1'b0, 8'd0, 9'd0};
    if (req == ohs_pkg::REQ_CLEAR) begin
      foreach (table_q[i]) table_q[i] = '0;
      live_q = '0;
    end else if (k == '0 || k == ohs_pkg::TOMB_KEY) begin
      a.status = ohs_pkg::STS_INVALID;
    end else begin
      pos = probe(k, h);
      hit = (table_q[pos] == k);
      if (hit) begin
        a.present = 1'b1;
        a.slot = pos;
      end
      if (req == ohs_pkg::REQ_INSERT && !hit) begin
        if (table_q[pos] == '0 || table_q[pos] == ohs_pkg::TOMB_KEY) begin
          table_q[pos] = k;
          live_q++;
          a.slot = pos;
        end else begin
          a.status = ohs_pkg::STS_FULL;
        end
      end else if (req == ohs_pkg::REQ_REMOVE && hit) begin
        table_q[pos] = ohs_pkg::TOMB_KEY;
        live_q--;
      end
    end
    a.count = live_q;
    answers_q.push_back(a);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t e;
    if (!rst_ni) begin
      foreach (table_q[i]) table_q[i] = '0;
      live_q = '0;
      modulus_q = ohs_pkg::MOD_RESET;
      answers_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) modulus_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        apply_request(ohs_pkg::req_e'(req_type_i), key_i, key_hash_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          report("unexpected result", 32'd1, 32'd0);
        end else begin
          e = answers_q.pop_front();
          if (status_o != e.status) report("status", status_o, e.status);
          if (present_o != e.present) report("present", present_o, e.present);
          if (slot_o != e.slot) report("slot", slot_o, e.slot);
          if (entry_count_o != e.count) report("entry_count", entry_count_o, e.count);
        end
      end
    end
    pending_count = answers_q.size();
  end
endmodule

// ===== verif/open_addressing_hash_set_top_tb.sv =====
// Testbench top of the hash set: stimulus, idling phases and verdict.
module open_addressing_hash_set_top_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] key_hash_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        present_o;
  logic [7:0]  slot_o;
  logic [8:0]  entry_count_o;
  int          fail_count;
  int          pending_count;

  // Idle odds in percent for sender and receiver; the phase changes them.
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 81;
  longint unsigned cycle_count = 0;
  // Keys used so far; reuse them so removes and lookups find hits.
  logic [31:0] key_pool [$];

  // Worst case per item: the modulus unit plus a read and a compare per slot over 256 slots.
  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  open_addressing_hash_set_top u_dut (.*);

  open_addressing_hash_set_checker u_check (.*);

  // Stall the receiver at random, changing only at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // End the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive one item and hold it until taken; idle before it at random.
  // Valid stays high after the taking edge until the next call or drain.
  task automatic send(ohs_pkg::req_e req, logic [31:0] k, logic [31:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    key_i <= k;
    key_hash_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid, wait until every result is back, then let the back end settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_modulus(logic [31:0] m);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Pick a key: reused or fresh in about equal shares, rarely reserved.
  function automatic logic [31:0] pick_key();
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    if (r < 55 && key_pool.size() != 0) return key_pool[$urandom_range(key_pool.size() - 1)];
    k = $urandom();
    if (k == '0 || k == '1) k = 32'h1;
    key_pool.push_back(k);
    if (key_pool.size() > 400) void'(key_pool.pop_front());
    return k;
  endfunction

  // Hash tied to the key mostly, so the same key probes from the same home.
  function automatic logic [31:0] hash_of(logic [31:0] k);
    return (k * 32'h9E37_79B1) ^ (k >> 7);
  endfunction

  task automatic random_items(int n);
    int unsigned r;
    logic [31:0] k;
    ohs_pkg::req_e req;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      req = (r < 45) ? ohs_pkg::REQ_INSERT : (r < 70) ? ohs_pkg::REQ_REMOVE :
            (r < 99) ? ohs_pkg::REQ_LOOKUP : ohs_pkg::REQ_CLEAR;
      k = pick_key();
      send(req, k, ($urandom_range(9) == 0) ? $urandom() : hash_of(k));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reserved keys, every request, extreme hashes and keys.
    send(ohs_pkg::REQ_INSERT, 32'h0, 32'h0);
    send(ohs_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_LOOKUP, 32'h0, 32'h1);
    send(ohs_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h5);
    send(ohs_pkg::REQ_INSERT, 32'h1, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_INSERT, 32'h1, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_REMOVE, 32'h1, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_LOOKUP, 32'h1, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_INSERT, 32'hAAAA_5555, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_REMOVE, 32'h1234, 32'h0);
    send(ohs_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ohs_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFF);

    // Modulus zero: home is the raw hash masked.
    set_modulus(32'h0);
    send(ohs_pkg::REQ_INSERT, 32'h5555_AAAA, 32'h0000_00FF);
    send(ohs_pkg::REQ_INSERT, 32'h7, 32'h0000_00FF);
    send(ohs_pkg::REQ_LOOKUP, 32'h7, 32'h0000_00FF);

    // Modulus one sends every key home to slot 0; fill the table to full.
    set_modulus(32'h1);
    send(ohs_pkg::REQ_CLEAR, 32'h0, 32'h0);
    for (int i = 1; i <= 257; i++) send(ohs_pkg::REQ_INSERT, 32'(i), $urandom());
    send(ohs_pkg::REQ_LOOKUP, 32'd300, 32'h0);
    send(ohs_pkg::REQ_REMOVE, 32'd100, 32'h0);
    send(ohs_pkg::REQ_INSERT, 32'd999, 32'h0);

    // Hold off until every result is back.
    drain();

    // Phase one: sender rarely idle, receiver mostly stalled.
    set_modulus(32'hFFFF_FFFF);
    send(ohs_pkg::REQ_CLEAR, 32'h0, 32'h0);
    random_items(260);
    set_modulus(32'd251);
    random_items(260);

    // Phase two: the other way round.
    send_idle_pct = 81;
    recv_idle_pct = 7;
    set_modulus(32'd13);
    random_items(260);
    set_modulus(32'd65_521);
    random_items(260);

    // Phase three: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_modulus(32'h0);
    random_items(260);
    set_modulus(32'd7);
    random_items(260);

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
